// ===== design/jbt_pkg.sv =====
package jbt_pkg;

    localparam int LineBitsDef   = 16;
    localparam int ColumnBitsDef = 16;

    // Event kinds.
    localparam logic [1:0] EV_CONTENT = 2'd0;
    localparam logic [1:0] EV_TOKEN   = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    // Token types.
    localparam logic [3:0] TK_LBRACE = 4'd0;
    localparam logic [3:0] TK_RBRACE = 4'd1;
    localparam logic [3:0] TK_LBRACK = 4'd2;
    localparam logic [3:0] TK_RBRACK = 4'd3;
    localparam logic [3:0] TK_COLON  = 4'd4;
    localparam logic [3:0] TK_COMMA  = 4'd5;
    localparam logic [3:0] TK_STRING = 4'd6;
    localparam logic [3:0] TK_INT    = 4'd7;
    localparam logic [3:0] TK_FLOAT  = 4'd8;
    localparam logic [3:0] TK_TRUE   = 4'd9;
    localparam logic [3:0] TK_FALSE  = 4'd10;
    localparam logic [3:0] TK_NULL   = 4'd11;
    localparam logic [3:0] TK_SYMBOL = 4'd12;
    localparam logic [3:0] TK_END    = 4'd13;

    // Error codes.
    localparam logic [2:0] ER_NUM_END = 3'd0;
    localparam logic [2:0] ER_CHAR    = 3'd1;
    localparam logic [2:0] ER_EOF_STR = 3'd2;
    localparam logic [2:0] ER_CTRL    = 3'd3;
    localparam logic [2:0] ER_ESC     = 3'd4;
    localparam logic [2:0] ER_HEX     = 3'd5;

    // Lexer modes.
    localparam logic [2:0] MD_IDLE = 3'd0;
    localparam logic [2:0] MD_NUM  = 3'd1;
    localparam logic [2:0] MD_SYM  = 3'd2;
    localparam logic [2:0] MD_STR  = 3'd3;
    localparam logic [2:0] MD_END  = 3'd4;

    // Number sub-states.
    localparam logic [3:0] NS_SIGN    = 4'd1;
    localparam logic [3:0] NS_ZERO    = 4'd2;
    localparam logic [3:0] NS_INT     = 4'd3;
    localparam logic [3:0] NS_POINT   = 4'd4;
    localparam logic [3:0] NS_FRAC    = 4'd5;
    localparam logic [3:0] NS_EXP     = 4'd6;
    localparam logic [3:0] NS_EXPSIGN = 4'd7;
    localparam logic [3:0] NS_EXPVAL  = 4'd8;

    // String sub-states; HEX0..HEX0+3 collect the four hex digits.
    localparam logic [3:0] SS_OPEN = 4'd1;
    localparam logic [3:0] SS_ESC  = 4'd2;
    localparam logic [3:0] SS_HEX0 = 4'd3;
    localparam logic [3:0] SS_HEX3 = 4'd6;

    localparam logic [15:0] Utf8Lim1 = 16'h0080;
    localparam logic [15:0] Utf8Lim2 = 16'h0800;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  Cont     = 8'h80;
    localparam logic [5:0]  Mask6    = 6'h3F;
    localparam logic [4:0]  Mask5    = 5'h1F;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ttype;
        logic [7:0] data;
        logic [2:0] err;
    } t_event;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // Prefix matcher: 1..4 true, 5..9 false, 10..13 null.
    function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        case (s)
            4'd1:  if (c == "r") r = 4'd2;
            4'd2:  if (c == "u") r = 4'd3;
            4'd3:  if (c == "e") r = 4'd4;
            4'd5:  if (c == "a") r = 4'd6;
            4'd6:  if (c == "l") r = 4'd7;
            4'd7:  if (c == "s") r = 4'd8;
            4'd8:  if (c == "e") r = 4'd9;
            4'd10: if (c == "u") r = 4'd11;
            4'd11: if (c == "l") r = 4'd12;
            4'd12: if (c == "l") r = 4'd13;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_type(input logic [3:0] s);
        logic [3:0] r;
        case (s)
            4'd4:    r = TK_TRUE;
            4'd9:    r = TK_FALSE;
            4'd13:   r = TK_NULL;
            default: r = TK_SYMBOL;
        endcase
        return r;
    endfunction

endpackage

// ===== design/json_byte_tokenizer_top.sv =====
// Byte-serial JSON lexer.
// Input channel: one text byte per transfer (i_text_byte, i_end_of_input),
// handshaked by i_in_valid / o_in_stall. Byte 0 also marks end of input.
// Output channel: result items on o_out_valid / i_out_stall, one per transfer;
// o_last_of_run marks the final result that a byte caused.
// Each byte is decoded in the cycle it is accepted into a bank of up to three
// results; the first appears in the cycle after acceptance. A byte that causes
// one result or none sustains one byte per cycle while the receiver does not
// stall. A byte that causes two or three results (a \u escape, or a pending
// token closed by punctuation or the end mark) holds the output until all are
// sent; the input is stalled while the bank holds more than its last result,
// or while the receiver stalls that one. Bytes that cause no result
// (whitespace, escape prefixes, hex digits) give no output transfer. After an
// error the block takes bytes and returns nothing until reset. After the end
// mark every byte returns one end token. Reset (synchronous, active low)
// returns to idle, line 1, column 0, and drops any results not yet delivered.
module json_byte_tokenizer_top #(
    parameter int LINE_BITS   = jbt_pkg::LineBitsDef,
    parameter int COLUMN_BITS = jbt_pkg::ColumnBitsDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_input,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_event_kind,
    output logic [3:0]             o_token_type,
    output logic [7:0]             o_data_byte,
    output logic [2:0]             o_error_code,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [COLUMN_BITS-1:0] o_column_number,
    output logic                   o_last_of_run
);
    import jbt_pkg::*;

    localparam logic [LINE_BITS-1:0]   LineMax = '1;
    localparam logic [COLUMN_BITS-1:0] ColMax  = '1;

    logic [2:0]             r_mode;
    logic [3:0]             r_sub;
    logic [15:0]            r_uacc;
    logic [3:0]             r_kw;
    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic                   r_halted;

    // Result bank: up to three results of one byte, r_cnt left to send.
    t_event                 r_ev [3];
    logic [1:0]             r_cnt;
    logic [1:0]             r_pos;
    logic [LINE_BITS-1:0]   r_ev_line;
    logic [COLUMN_BITS-1:0] r_ev_col;

    logic [2:0]             n_mode;
    logic [3:0]             n_sub;
    logic [15:0]            n_uacc;
    logic [3:0]             n_kw;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] n_col;
    logic                   n_halted;
    t_event                 n_ev [3];
    logic [1:0]             n_n;
    logic [COLUMN_BITS-1:0] col_inc;

    logic accept, out_xfer, bank_free;

    assign out_xfer  = o_out_valid && !i_out_stall;
    assign bank_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_out_stall);
    assign o_in_stall = !bank_free;
    assign accept    = i_in_valid && bank_free;

    always_comb begin
        logic [7:0]  c;
        logic        eof;
        logic        ok;
        logic        nl;
        logic [3:0]  h;
        logic        hv;
        logic [15:0] u;
        logic [3:0]  nx;
        logic [7:0]  d;
        logic        dv;
        t_event      e;

        c  = i_text_byte;
        eof = i_end_of_input || (c == 8'd0);
        ok = 1'b1;
        nl = 1'b0;
        h  = 4'd0;
        hv = 1'b0;
        u  = 16'd0;
        nx = 4'd0;
        d  = 8'd0;
        dv = 1'b1;
        e  = '0;
        n_mode   = r_mode;
        n_sub    = r_sub;
        n_uacc   = r_uacc;
        n_kw     = r_kw;
        n_line   = r_line;
        n_halted = r_halted;
        n_n      = 2'd0;
        for (int k = 0; k < 3; k++) n_ev[k] = '0;
        col_inc  = (r_col < ColMax) ? r_col + 1'b1 : r_col;
        n_col    = r_col;

        if (r_halted) begin
            n_n = 2'd0;
        end else if (r_mode == MD_END) begin
            n_ev[0] = '{kind: EV_TOKEN, ttype: TK_END, data: 8'd0, err: 3'd0};
            n_n = 2'd1;
        end else begin
            n_col = col_inc;
            if (r_mode == MD_STR) begin
                if (eof) begin
                    n_ev[0] = '{kind: EV_ERROR, ttype: 4'd0, data: 8'd0, err: ER_EOF_STR};
                    n_n = 2'd1; n_halted = 1'b1;
                end else if (c < 8'h20) begin
                    n_ev[0] = '{kind: EV_ERROR, ttype: 4'd0, data: 8'd0, err: ER_CTRL};
                    n_n = 2'd1; n_halted = 1'b1;
                end else if (r_sub == SS_ESC) begin
                    case (c)
                        "\"":    d = 8'h22;
                        "\\":    d = 8'h5C;
                        "/":     d = 8'h2F;
                        "b":     d = 8'h08;
                        "f":     d = 8'h0C;
                        "n":     d = 8'h0A;
                        "r":     d = 8'h0D;
                        "t":     d = 8'h09;
                        default: dv = 1'b0;
                    endcase
                    if (c == "u") begin
                        n_sub = SS_HEX0; n_uacc = 16'd0;
                    end else if (dv) begin
                        n_ev[0] = '{kind: EV_CONTENT, ttype: 4'd0, data: d, err: 3'd0};
                        n_n = 2'd1; n_sub = SS_OPEN;
                    end else begin
                        n_ev[0] = '{kind: EV_ERROR, ttype: 4'd0, data: 8'd0, err: ER_ESC};
                        n_n = 2'd1; n_halted = 1'b1;
                    end
                end else if (r_sub >= SS_HEX0 && r_sub <= SS_HEX3) begin
                    if (is_digit(c)) begin
                        h = c[3:0]; hv = 1'b1;
                    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                        h = c[3:0] + 4'd9; hv = 1'b1;
                    end
                    if (!hv) begin
                        n_ev[0] = '{kind: EV_ERROR, ttype: 4'd0, data: 8'd0, err: ER_HEX};
                        n_n = 2'd1; n_halted = 1'b1;
                    end else begin
                        u = {r_uacc[11:0], h};
                        n_uacc = u;
                        if (r_sub != SS_HEX3) begin
                            n_sub = r_sub + 4'd1;
                        end else begin
                            n_sub = SS_OPEN;
                            if (u < Utf8Lim1) begin
                                n_ev[0] = '{EV_CONTENT, 4'd0, u[7:0], 3'd0};
                                n_n = 2'd1;
                            end else if (u < Utf8Lim2) begin
                                n_ev[0] = '{EV_CONTENT, 4'd0,
                                            {3'd0, u[10:6] & Mask5} | Lead2, 3'd0};
                                n_ev[1] = '{EV_CONTENT, 4'd0,
                                            {2'd0, u[5:0] & Mask6} | Cont, 3'd0};
                                n_n = 2'd2;
                            end else begin
                                n_ev[0] = '{EV_CONTENT, 4'd0, {4'd0, u[15:12]} | Lead3, 3'd0};
                                n_ev[1] = '{EV_CONTENT, 4'd0,
                                            {2'd0, u[11:6] & Mask6} | Cont, 3'd0};
                                n_ev[2] = '{EV_CONTENT, 4'd0,
                                            {2'd0, u[5:0] & Mask6} | Cont, 3'd0};
                                n_n = 2'd3;
                            end
                        end
                    end
                end else if (c == "\\") begin
                    n_sub = SS_ESC;
                end else if (c == "\"") begin
                    n_ev[0] = '{EV_TOKEN, TK_STRING, 8'd0, 3'd0};
                    n_n = 2'd1; n_mode = MD_IDLE; n_sub = 4'd0;
                end else begin
                    n_ev[0] = '{EV_CONTENT, 4'd0, c, 3'd0};
                    n_n = 2'd1;
                end
            end else begin
                // Bytes that end a pending number or symbol.
                logic term;
                term = eof || c == " " || c == 8'h0A || c == 8'h0D || c == 8'h09 ||
                       c == 8'h0C || c == "{" || c == "}" || c == "[" || c == "]" ||
                       c == ":" || c == "," || c == "\"";
                if (term) begin
                    e = '0;
                    if (r_mode == MD_NUM) begin
                        if (r_sub == NS_SIGN || r_sub == NS_POINT || r_sub == NS_EXP ||
                            r_sub == NS_EXPSIGN) begin
                            ok = 1'b0;
                            n_ev[0] = '{EV_ERROR, 4'd0, 8'd0, ER_NUM_END};
                            n_n = 2'd1; n_halted = 1'b1;
                        end else begin
                            n_ev[0] = '{EV_TOKEN, (r_sub < NS_POINT) ? TK_INT : TK_FLOAT,
                                        8'd0, 3'd0};
                            n_n = 2'd1;
                        end
                    end else if (r_mode == MD_SYM) begin
                        n_ev[0] = '{EV_TOKEN, kw_type(r_kw), 8'd0, 3'd0};
                        n_n = 2'd1;
                    end
                    if (ok) begin
                        n_mode = MD_IDLE; n_sub = 4'd0; n_kw = 4'd0;
                        e.kind = EV_TOKEN;
                        dv = 1'b1;
                        if (eof) begin
                            e.ttype = TK_END; n_mode = MD_END;
                        end else begin
                            case (c)
                                "{":     e.ttype = TK_LBRACE;
                                "}":     e.ttype = TK_RBRACE;
                                "[":     e.ttype = TK_LBRACK;
                                "]":     e.ttype = TK_RBRACK;
                                ":":     e.ttype = TK_COLON;
                                ",":     e.ttype = TK_COMMA;
                                default: dv = 1'b0;
                            endcase
                            if (c == "\"") begin
                                n_mode = MD_STR; n_sub = SS_OPEN;
                            end
                            nl = (c == 8'h0A);
                        end
                        if (dv) begin
                            n_ev[n_n] = e;
                            n_n = n_n + 2'd1;
                        end
                    end
                end else if (r_mode == MD_NUM) begin
                    case (r_sub)
                        NS_SIGN:    if (c == "0") nx = NS_ZERO;
                                    else if (is_digit(c)) nx = NS_INT;
                        NS_ZERO:    if (c == ".") nx = NS_POINT;
                                    else if (c == "e" || c == "E") nx = NS_EXP;
                        NS_INT:     if (c == ".") nx = NS_POINT;
                                    else if (c == "e" || c == "E") nx = NS_EXP;
                                    else if (is_digit(c)) nx = NS_INT;
                        NS_POINT:   if (is_digit(c)) nx = NS_FRAC;
                        NS_FRAC:    if (is_digit(c)) nx = NS_FRAC;
                                    else if (c == "e" || c == "E") nx = NS_EXP;
                        NS_EXP:     if (c == "+" || c == "-") nx = NS_EXPSIGN;
                                    else if (is_digit(c)) nx = NS_EXPVAL;
                        NS_EXPSIGN: if (is_digit(c)) nx = NS_EXPVAL;
                        NS_EXPVAL:  if (is_digit(c)) nx = NS_EXPVAL;
                        default:    nx = 4'd0;
                    endcase
                    n_n = 2'd1;
                    if (nx == 4'd0) begin
                        n_ev[0] = '{EV_ERROR, 4'd0, 8'd0, ER_CHAR};
                        n_halted = 1'b1;
                    end else begin
                        n_ev[0] = '{EV_CONTENT, 4'd0, c, 3'd0};
                        n_sub = nx;
                    end
                end else if (r_mode == MD_SYM) begin
                    n_n = 2'd1;
                    if (is_ident(c) || is_digit(c)) begin
                        n_kw = kw_next(r_kw, c);
                        n_ev[0] = '{EV_CONTENT, 4'd0, c, 3'd0};
                    end else begin
                        n_ev[0] = '{EV_ERROR, 4'd0, 8'd0, ER_CHAR};
                        n_halted = 1'b1;
                    end
                end else begin
                    n_n = 2'd1;
                    if (c == "-" || is_digit(c)) begin
                        n_mode = MD_NUM;
                        n_sub = (c == "-") ? NS_SIGN : (c == "0") ? NS_ZERO : NS_INT;
                        n_ev[0] = '{EV_CONTENT, 4'd0, c, 3'd0};
                    end else if (is_ident(c)) begin
                        n_mode = MD_SYM; n_sub = 4'd0;
                        n_kw = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 :
                               (c == "n") ? 4'd10 : 4'd0;
                        n_ev[0] = '{EV_CONTENT, 4'd0, c, 3'd0};
                    end else begin
                        n_ev[0] = '{EV_ERROR, 4'd0, 8'd0, ER_CHAR};
                        n_halted = 1'b1;
                    end
                end
            end
        end
        if (nl) begin
            n_col = '0;
            n_line = (r_line < LineMax) ? r_line + 1'b1 : r_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MD_IDLE;
            r_sub    <= 4'd0;
            r_uacc   <= 16'd0;
            r_kw     <= 4'd0;
            r_line   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_col    <= '0;
            r_halted <= 1'b0;
            r_cnt    <= 2'd0;
            r_pos    <= 2'd0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_sub    <= n_sub;
                r_uacc   <= n_uacc;
                r_kw     <= n_kw;
                r_line   <= n_line;
                r_col    <= n_col;
                r_halted <= n_halted;
                r_cnt    <= n_n;
                r_pos    <= 2'd0;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 2'd1;
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // Results report the counters before any newline update of the same byte.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) r_ev[k] <= n_ev[k];
            r_ev_line <= r_line;
            r_ev_col  <= (r_halted || r_mode == MD_END) ? r_col : col_inc;
        end
    end

    t_event cur;
    always_comb begin
        case (r_pos)
            2'd0:    cur = r_ev[0];
            2'd1:    cur = r_ev[1];
            2'd2:    cur = r_ev[2];
            default: cur = r_ev[0];
        endcase
    end

    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_event_kind    = cur.kind;
    assign o_token_type    = cur.ttype;
    assign o_data_byte     = cur.data;
    assign o_error_code    = cur.err;
    assign o_line_number   = r_ev_line;
    assign o_column_number = r_ev_col;
    assign o_last_of_run   = (r_cnt == 2'd1);

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> o_in_stall)
        else $error("input taken while result bank holds several results");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_halted) && r_halted && $past(accept)) |-> (r_cnt == 2'd0))
        else $error("results produced after halt");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_ERROR) |-> (o_last_of_run && r_halted))
        else $error("error result is not final");
`endif

endmodule

// ===== tb/tb_json_byte_tokenizer_top.sv =====
module tb_json_byte_tokenizer_top;
    import jbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [7:0] text;
        logic       eoi;
    } t_byte_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  ttype;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_lex_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_input;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_event_kind;
    logic [3:0]  o_token_type;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_error_code;
    logic [15:0] o_line_number;
    logic [15:0] o_column_number;
    logic        o_last_of_run;

    json_byte_tokenizer_top DUT (.*);

    // Lexer state mirrored by the predictor.
    logic [2:0]  lx_mode;
    logic [3:0]  lx_sub;
    logic [15:0] lx_uacc;
    logic [3:0]  lx_kw;
    logic [15:0] lx_line;
    logic [15:0] lx_col;
    logic        lx_halted;
    t_event      step_events[$];

    t_byte_in    text_queue[$];
    t_lex_result expected_results[$];

    int  mismatches;
    int  bytes_sent;
    int  results_seen;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_count;
    bit  sender_pause;
    bit  in_taken;

    always #2ns i_clk = ~i_clk;

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ident_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [3:0] keyword_advance(logic [3:0] s, logic [7:0] c);
        string words[3] = '{"true", "false", "null"};
        int w;
        int len;
        if (s >= 1 && s <= 4) begin
            w = 0; len = s;
        end else if (s >= 5 && s <= 9) begin
            w = 1; len = s - 4;
        end else if (s >= 10 && s <= 13) begin
            w = 2; len = s - 9;
        end else begin
            return 4'd0;
        end
        if (len < words[w].len() && words[w][len] == c) return s + 4'd1;
        return 4'd0;
    endfunction

    function automatic logic [3:0] keyword_token(logic [3:0] s);
        case (s)
            4'd4:    return TK_TRUE;
            4'd9:    return TK_FALSE;
            4'd13:   return TK_NULL;
            default: return TK_SYMBOL;
        endcase
    endfunction

    function automatic void push_event(logic [1:0] k, logic [3:0] t, logic [7:0] d,
                                       logic [2:0] e);
        t_event ev;
        if (step_events.size() < 3) begin
            ev.kind = k; ev.ttype = t; ev.data = d; ev.err = e;
            step_events.push_back(ev);
        end
    endfunction

    function automatic void raise_error(logic [2:0] code);
        push_event(EV_ERROR, TK_LBRACE, 8'd0, code);
        lx_halted = 1'b1;
    endfunction

    // Completes an open number or symbol; returns 0 when that is an error.
    function automatic bit finish_token();
        if (lx_mode == MD_NUM) begin
            if (lx_sub == NS_SIGN || lx_sub == NS_POINT || lx_sub == NS_EXP ||
                lx_sub == NS_EXPSIGN) begin
                raise_error(ER_NUM_END);
                return 0;
            end
            push_event(EV_TOKEN, lx_sub < NS_POINT ? TK_INT : TK_FLOAT, 8'd0, ER_NUM_END);
        end else if (lx_mode == MD_SYM) begin
            push_event(EV_TOKEN, keyword_token(lx_kw), 8'd0, ER_NUM_END);
        end
        lx_mode = MD_IDLE;
        lx_sub = 4'd0;
        lx_kw = 4'd0;
        return 1;
    endfunction

    function automatic void number_byte(logic [7:0] c);
        logic [3:0] nx;
        bit ex;
        nx = 4'd0;
        ex = (c == "e" || c == "E");
        case (lx_sub)
            NS_SIGN:    if (c == "0") nx = NS_ZERO; else if (digit_char(c)) nx = NS_INT;
            NS_ZERO:    if (c == ".") nx = NS_POINT; else if (ex) nx = NS_EXP;
            NS_INT:     if (c == ".") nx = NS_POINT; else if (ex) nx = NS_EXP;
                        else if (digit_char(c)) nx = NS_INT;
            NS_POINT:   if (digit_char(c)) nx = NS_FRAC;
            NS_FRAC:    if (digit_char(c)) nx = NS_FRAC; else if (ex) nx = NS_EXP;
            NS_EXP:     if (c == "+" || c == "-") nx = NS_EXPSIGN;
                        else if (digit_char(c)) nx = NS_EXPVAL;
            NS_EXPSIGN: if (digit_char(c)) nx = NS_EXPVAL;
            NS_EXPVAL:  if (digit_char(c)) nx = NS_EXPVAL;
            default:    nx = 4'd0;
        endcase
        if (nx == 4'd0) begin
            raise_error(ER_CHAR);
        end else begin
            lx_sub = nx;
            push_event(EV_CONTENT, TK_LBRACE, c, ER_NUM_END);
        end
    endfunction

    function automatic void string_byte(logic [7:0] c);
        logic [7:0] d;
        int h;
        logic [15:0] u;
        if (c < 8'h20) begin
            raise_error(ER_CTRL);
        end else if (lx_sub == SS_ESC) begin
            case (c)
                "\"":    d = "\"";
                "\\":    d = "\\";
                "/":     d = "/";
                "b":     d = 8'h08;
                "f":     d = 8'h0C;
                "n":     d = 8'h0A;
                "r":     d = 8'h0D;
                "t":     d = 8'h09;
                "u": begin
                    lx_sub = SS_HEX0;
                    lx_uacc = 16'd0;
                    return;
                end
                default: begin
                    raise_error(ER_ESC);
                    return;
                end
            endcase
            push_event(EV_CONTENT, TK_LBRACE, d, ER_NUM_END);
            lx_sub = SS_OPEN;
        end else if (lx_sub >= SS_HEX0 && lx_sub <= SS_HEX3) begin
            h = hex_value(c);
            if (h < 0) begin
                raise_error(ER_HEX);
                return;
            end
            lx_uacc = {lx_uacc[11:0], 4'(h)};
            if (lx_sub < SS_HEX3) begin
                lx_sub++;
                return;
            end
            u = lx_uacc;
            if (u < 16'h0080) begin
                push_event(EV_CONTENT, TK_LBRACE, u[7:0], ER_NUM_END);
            end else if (u < 16'h0800) begin
                push_event(EV_CONTENT, TK_LBRACE, {3'b110, u[10:6]}, ER_NUM_END);
                push_event(EV_CONTENT, TK_LBRACE, {2'b10, u[5:0]}, ER_NUM_END);
            end else begin
                push_event(EV_CONTENT, TK_LBRACE, {4'b1110, u[15:12]}, ER_NUM_END);
                push_event(EV_CONTENT, TK_LBRACE, {2'b10, u[11:6]}, ER_NUM_END);
                push_event(EV_CONTENT, TK_LBRACE, {2'b10, u[5:0]}, ER_NUM_END);
            end
            lx_sub = SS_OPEN;
        end else if (c == "\\") begin
            lx_sub = SS_ESC;
        end else if (c == "\"") begin
            push_event(EV_TOKEN, TK_STRING, 8'd0, ER_NUM_END);
            lx_mode = MD_IDLE;
            lx_sub = 4'd0;
        end else begin
            push_event(EV_CONTENT, TK_LBRACE, c, ER_NUM_END);
        end
    endfunction

    function automatic void punct(logic [3:0] t);
        if (finish_token()) push_event(EV_TOKEN, t, 8'd0, ER_NUM_END);
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void tokenize_byte(t_byte_in b);
        logic [7:0] c;
        bit eof;
        bit newline;
        t_lex_result r;
        c = b.text;
        eof = b.eoi || c == 8'd0;
        newline = 0;
        step_events.delete();
        if (lx_halted) return;
        if (lx_mode == MD_END) begin
            push_event(EV_TOKEN, TK_END, 8'd0, ER_NUM_END);
        end else begin
            if (lx_col != 16'hFFFF) lx_col++;
            if (lx_mode == MD_STR) begin
                if (eof) raise_error(ER_EOF_STR);
                else string_byte(c);
            end else if (eof) begin
                if (finish_token()) begin
                    push_event(EV_TOKEN, TK_END, 8'd0, ER_NUM_END);
                    lx_mode = MD_END;
                end
            end else begin
                case (c)
                    " ", "\n", "\r", "\t", 8'h0C: begin
                        if (finish_token() && c == "\n") newline = 1;
                    end
                    "{": punct(TK_LBRACE);
                    "}": punct(TK_RBRACE);
                    "[": punct(TK_LBRACK);
                    "]": punct(TK_RBRACK);
                    ":": punct(TK_COLON);
                    ",": punct(TK_COMMA);
                    "\"": begin
                        if (finish_token()) begin
                            lx_mode = MD_STR;
                            lx_sub = SS_OPEN;
                        end
                    end
                    default: begin
                        if (lx_mode == MD_NUM) begin
                            number_byte(c);
                        end else if (lx_mode == MD_SYM) begin
                            if (ident_char(c) || digit_char(c)) begin
                                lx_kw = keyword_advance(lx_kw, c);
                                push_event(EV_CONTENT, TK_LBRACE, c, ER_NUM_END);
                            end else begin
                                raise_error(ER_CHAR);
                            end
                        end else if (c == "-" || digit_char(c)) begin
                            lx_mode = MD_NUM;
                            lx_sub = (c == "-") ? NS_SIGN : (c == "0") ? NS_ZERO : NS_INT;
                            push_event(EV_CONTENT, TK_LBRACE, c, ER_NUM_END);
                        end else if (ident_char(c)) begin
                            lx_mode = MD_SYM;
                            lx_sub = 4'd0;
                            lx_kw = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 :
                                    (c == "n") ? 4'd10 : 4'd0;
                            push_event(EV_CONTENT, TK_LBRACE, c, ER_NUM_END);
                        end else begin
                            raise_error(ER_CHAR);
                        end
                    end
                endcase
            end
        end
        foreach (step_events[k]) begin
            r.kind = step_events[k].kind;
            r.ttype = step_events[k].ttype;
            r.data = step_events[k].data;
            r.err = step_events[k].err;
            r.line = lx_line;
            r.col = lx_col;
            r.last = (k == step_events.size() - 1);
            expected_results.push_back(r);
        end
        if (newline) begin
            lx_col = 16'd0;
            if (lx_line != 16'hFFFF) lx_line++;
        end
    endfunction

    function automatic void lexer_reset();
        lx_mode = MD_IDLE;
        lx_sub = 4'd0;
        lx_uacc = 16'd0;
        lx_kw = 4'd0;
        lx_line = 16'd1;
        lx_col = 16'd0;
        lx_halted = 1'b0;
    endfunction

    // Driver: holds a byte until it is taken, then offers the next one.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (text_queue.size() > 0 && !sender_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_text_byte <= text_queue[0].text;
                    i_end_of_input <= text_queue[0].eoi;
                    void'(text_queue.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                    i_text_byte <= 8'($urandom);
                    i_end_of_input <= 1'($urandom);
                end
            end
            if (hold_count > 0) begin
                hold_count <= hold_count - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        t_byte_in    b;
        t_lex_result got;
        t_lex_result want;
        bit          moved;
        moved = 0;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                b.text = i_text_byte;
                b.eoi = i_end_of_input;
                tokenize_byte(b);
                bytes_sent <= bytes_sent + 1;
                moved = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1;
                results_seen <= results_seen + 1;
                got = '{o_event_kind, o_token_type, o_data_byte, o_error_code,
                        o_line_number, o_column_number, o_last_of_run};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: %p", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic queue_text(string s);
        t_byte_in b;
        for (int k = 0; k < s.len(); k++) begin
            b.text = s[k];
            b.eoi = 1'b0;
            text_queue.push_back(b);
        end
    endtask

    task automatic queue_raw(logic [7:0] c, logic e);
        t_byte_in b;
        b.text = c;
        b.eoi = e;
        text_queue.push_back(b);
    endtask

    // Waits until the driver has sent everything and every result has come.
    task automatic drain();
        while (text_queue.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Picks a short piece of JSON text followed by a separator.
    function automatic string random_fragment();
        string frags[24] = '{"123", "-0.5e+7", "0", "1.25E-3", "true", "false", "null",
            "tru", "nullx", "abc_9", "\"hi\"", "\"a\\nb\"", "\"\\u00e9\"", "\"\\u20AC\"",
            "\"\\u0041\"", "\"\\t\\/\\\\\"", "{", "}", "[", "]", ":", ",", "\"\\uFFFF\"",
            "-12e5"};
        string ws[4] = '{" ", "\n", "\t", "\r"};
        string s;
        s = frags[$urandom_range(23)];
        if ($urandom_range(3) == 0) s = {s, ws[$urandom_range(3)]};
        else if ($urandom_range(1) == 0) s = {s, ","};
        else s = {s, " "};
        return s;
    endfunction

    initial begin
        int n;
        string doc;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_text_byte = 8'd0;
        i_end_of_input = 1'b0;
        i_out_stall = 1'b0;
        mismatches = 0;
        bytes_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_count = 0;
        sender_pause = 1'b0;
        in_taken = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 67;
        lexer_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: punctuation, numbers, keywords, escapes, a newline, high bytes.
        queue_text("{\"k\":[0,-1.5e+3,12E7,true,false,null,sym_Z9]}\n");
        queue_text("\"\\b\\f\\r\\\"\\u0000\\u07FF\\uD800");
        queue_raw(8'hFF, 1'b0);
        queue_text("\" -0 ");
        // An ordinary byte flagged as end of input, then bytes after the end.
        queue_raw(8'h41, 1'b1);
        queue_raw(8'h7B, 1'b0);
        queue_raw(8'h00, 1'b1);
        drain();

        // The block stays ended until reset, and reset happens only once, so
        // the remaining random traffic checks the after-end behavior at length;
        // the bulk of well-formed text was covered above. Extra random bytes
        // in every bit position exercise the ignored payload as well.
        send_idle_pct = 67;
        recv_idle_pct = 13;
        for (n = 0; n < 10; n++) queue_raw(8'($urandom), 1'($urandom));
        // Long receiver hold-off while the sender keeps offering.
        hold_count = 60;
        drain();
        sender_pause = 1'b1;
        drain();
        sender_pause = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        doc = "";
        for (n = 0; n < 3; n++) doc = {doc, random_fragment()};
        queue_text(doc);
        for (n = 0; n < 5; n++) queue_raw(8'($urandom), 1'($urandom));
        drain();

        $display("Sent %0d bytes of JSON text and checked %0d results.", bytes_sent,
                 results_seen);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
